// ----- src/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, request codes and microcode table for the character-LCD
// command sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam int MAX_ROWS_DEF = 4;
    localparam int PC_W         = 4;

    // request codes
    localparam logic [3:0] REQ_INIT       = 4'd0;
    localparam logic [3:0] REQ_CHAR       = 4'd1;
    localparam logic [3:0] REQ_CURSOR_POS = 4'd2;
    localparam logic [3:0] REQ_CLEAR      = 4'd3;
    localparam logic [3:0] REQ_HOME       = 4'd4;
    localparam logic [3:0] REQ_CURSOR_ON  = 4'd5;
    localparam logic [3:0] REQ_CURSOR_OFF = 4'd6;
    localparam logic [3:0] REQ_BLINK_ON   = 4'd7;
    localparam logic [3:0] REQ_BLINK_OFF  = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_BIT = 2'd0;
    localparam logic [1:0] CFG_COLUMNS  = 2'd1;
    localparam logic [1:0] CFG_ROWS     = 2'd2;

    // controller command bytes
    localparam logic [7:0] CMD_WAKE_8   = 8'h33;
    localparam logic [7:0] CMD_WAKE_4   = 8'h32;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_SHIFT    = 8'h14;
    localparam logic [7:0] CMD_FUNC_4   = 8'h28;
    localparam logic [7:0] CMD_FUNC_8   = 8'h38;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] DISP_CTRL_RST = 8'h0C;
    localparam logic [7:0] BIT_CURSOR   = 8'h02;
    localparam logic [7:0] BIT_BLINK    = 8'h01;
    localparam logic [2:0] PAUSE_MS     = 3'd5;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_CHAR,
        SRC_CURSOR,
        SRC_SHADOW,
        SRC_FUNC
    } src_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_INIT,
        SH_REQ
    } shadow_op_t;

    typedef struct packed {
        logic             emit;
        src_t             src;
        logic [7:0]       value;
        logic             rs;
        logic             pause;
        logic             done;
        logic             jmp_eight;
        logic [PC_W-1:0]  target;
        shadow_op_t       sh_op;
    } ucode_t;

    typedef struct packed {
        logic             ok;
        logic [PC_W-1:0]  pc;
    } entry_t;

    // sequencer -> datapath control
    typedef struct packed {
        logic       load;
        logic       step;
        src_t       src;
        logic [7:0] value;
        shadow_op_t sh_op;
    } dp_ctrl_t;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        unique case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic ucode_t uw(input logic emit, input src_t src,
                                  input logic [7:0] value, input logic rs,
                                  input logic pause, input logic done,
                                  input logic jmp_eight,
                                  input logic [PC_W-1:0] target,
                                  input shadow_op_t sh_op);
        ucode_t w;
        w.emit      = emit;
        w.src       = src;
        w.value     = value;
        w.rs        = rs;
        w.pause     = pause;
        w.done      = done;
        w.jmp_eight = jmp_eight;
        w.target    = target;
        w.sh_op     = sh_op;
        return w;
    endfunction

    // microprogram
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            // init: wake-up triple only on the 4-bit bus
            4'd0:  w = uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd4, SH_NONE);
            4'd1:  w = uw(1'b1, SRC_CONST, CMD_WAKE_8, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd2:  w = uw(1'b1, SRC_CONST, CMD_WAKE_8, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd3:  w = uw(1'b1, SRC_CONST, CMD_WAKE_4, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd4:  w = uw(1'b1, SRC_CONST, CMD_ENTRY, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, SH_INIT);
            4'd5:  w = uw(1'b1, SRC_SHADOW, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd6:  w = uw(1'b1, SRC_CONST, CMD_SHIFT, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd7:  w = uw(1'b1, SRC_FUNC, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd8:  w = uw(1'b1, SRC_CONST, CMD_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, SH_NONE);
            4'd9:  w = uw(1'b1, SRC_CONST, CMD_HOME, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, SH_NONE);
            // single-transfer requests
            4'd10: w = uw(1'b1, SRC_CHAR, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0, SH_NONE);
            4'd11: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, SH_NONE);
            4'd12: w = uw(1'b1, SRC_CONST, CMD_CLEAR, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, SH_NONE);
            4'd13: w = uw(1'b1, SRC_CONST, CMD_HOME, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, SH_NONE);
            // display-control update, then send shadow
            4'd14: w = uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, SH_REQ);
            default: w = uw(1'b1, SRC_SHADOW, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, SH_NONE);
        endcase
        return w;
    endfunction

    function automatic entry_t entry_pc(input logic [3:0] req);
        entry_t e;
        e.ok = 1'b1;
        unique case (req)
            REQ_INIT:       e.pc = 4'd0;
            REQ_CHAR:       e.pc = 4'd10;
            REQ_CURSOR_POS: e.pc = 4'd11;
            REQ_CLEAR:      e.pc = 4'd12;
            REQ_HOME:       e.pc = 4'd13;
            REQ_CURSOR_ON,
            REQ_CURSOR_OFF,
            REQ_BLINK_ON,
            REQ_BLINK_OFF:  e.pc = 4'd14;
            default:
            begin
                e.ok = 1'b0;
                e.pc = 4'd0;
            end
        endcase
        return e;
    endfunction

endpackage

// ----- src/clcd_req_if.sv -----
// ----------------------------------------------------------------------------
// clcd_req_if
// Request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] req_type;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;

    modport source (output valid, req_type, char_code, column, row, input ready);
    modport sink   (input valid, req_type, char_code, column, row, output ready);
endinterface

// ----- src/clcd_xfer_if.sv -----
// ----------------------------------------------------------------------------
// clcd_xfer_if
// Transfer channel: valid/ready with one bus transfer.
// ----------------------------------------------------------------------------
interface clcd_xfer_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [7:0] bus_value;
    logic [2:0] pause_after_ms;
    logic       last;

    modport source (output valid, register_select, bus_value, pause_after_ms, last,
                    input ready);
    modport sink   (input valid, register_select, bus_value, pause_after_ms, last,
                    output ready);
endinterface

// ----- src/clcd_dp.sv -----
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath: configuration registers, latched request, display-control
// shadow and byte selection for the sequencer.
// ----------------------------------------------------------------------------
module clcd_dp #(
    parameter int MAX_ROWS = clcd_pkg::MAX_ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    clcd_req_if.sink            req,
    input  clcd_pkg::dp_ctrl_t  ctrl,
    output logic [7:0]          byte_val,
    output logic                four_bit
);

    localparam logic [2:0] MaxRowsC = 3'(MAX_ROWS);

    logic       four_bit_reg, four_bit_next;
    logic [5:0] columns_reg, columns_next;
    logic [2:0] rows_reg, rows_next;
    logic [7:0] shadow_reg, shadow_next;
    logic [3:0] req_type_reg, req_type_next;
    logic [7:0] char_code_reg, char_code_next;
    logic [7:0] column_reg, column_next;
    logic [7:0] row_reg, row_next;

    logic [7:0] max_col;
    logic [2:0] num_rows;
    logic [7:0] max_row;
    logic [7:0] col_c;
    logic [7:0] row_c;
    logic [7:0] cursor_cmd;

    always_comb
    begin
        max_col  = (columns_reg != 6'd0) ? {2'b00, columns_reg - 6'd1} : 8'd0;
        num_rows = (rows_reg > MaxRowsC) ? MaxRowsC : rows_reg;
        max_row  = (num_rows != 3'd0) ? {5'd0, num_rows - 3'd1} : 8'd0;
        col_c    = (column_reg > max_col) ? max_col : column_reg;
        row_c    = (row_reg > max_row) ? max_row : row_reg;
        cursor_cmd = clcd_pkg::CMD_DDRAM | (clcd_pkg::row_base(row_c[1:0]) + col_c);
    end

    always_comb
    begin
        unique case (ctrl.src)
            clcd_pkg::SRC_CHAR:   byte_val = char_code_reg;
            clcd_pkg::SRC_CURSOR: byte_val = cursor_cmd;
            clcd_pkg::SRC_SHADOW: byte_val = shadow_reg;
            clcd_pkg::SRC_FUNC:   byte_val = four_bit_reg ? clcd_pkg::CMD_FUNC_4
                                                          : clcd_pkg::CMD_FUNC_8;
            default:              byte_val = ctrl.value;
        endcase
    end

    assign four_bit = four_bit_reg;

    always_comb
    begin
        four_bit_next  = four_bit_reg;
        columns_next   = columns_reg;
        rows_next      = rows_reg;
        shadow_next    = shadow_reg;
        req_type_next  = req_type_reg;
        char_code_next = char_code_reg;
        column_next    = column_reg;
        row_next       = row_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                clcd_pkg::CFG_FOUR_BIT: four_bit_next = cfg_data[0];
                clcd_pkg::CFG_COLUMNS:  columns_next  = cfg_data;
                clcd_pkg::CFG_ROWS:     rows_next     = cfg_data[2:0];
                default: ;
            endcase
        end

        if (ctrl.load)
        begin
            req_type_next  = req.req_type;
            char_code_next = req.char_code;
            column_next    = req.column;
            row_next       = req.row;
        end

        if (ctrl.step)
        begin
            unique case (ctrl.sh_op)
                clcd_pkg::SH_INIT: shadow_next = clcd_pkg::DISP_CTRL_RST;
                clcd_pkg::SH_REQ:
                begin
                    case (req_type_reg)
                        clcd_pkg::REQ_CURSOR_ON:  shadow_next = shadow_reg | clcd_pkg::BIT_CURSOR;
                        clcd_pkg::REQ_CURSOR_OFF: shadow_next = shadow_reg & ~clcd_pkg::BIT_CURSOR;
                        clcd_pkg::REQ_BLINK_ON:   shadow_next = shadow_reg | clcd_pkg::BIT_BLINK;
                        clcd_pkg::REQ_BLINK_OFF:  shadow_next = shadow_reg & ~clcd_pkg::BIT_BLINK;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg <= 1'b1;
            columns_reg  <= 6'd16;
            rows_reg     <= 3'd2;
            shadow_reg   <= clcd_pkg::DISP_CTRL_RST;
        end
        else
        begin
            four_bit_reg <= four_bit_next;
            columns_reg  <= columns_next;
            rows_reg     <= rows_next;
            shadow_reg   <= shadow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        char_code_reg <= char_code_next;
        column_reg    <= column_next;
        row_reg       <= row_next;
    end

    // display bit must survive every shadow update
    a_shadow_display_on: assert property (@(posedge clk) disable iff (!rst_n)
        shadow_reg[3:2] == 2'b11)
        else $error("display-control shadow lost display bits");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_c <= 8'd62) && (row_c <= 8'd3))
        else $error("clamped cursor out of range");

    a_load_idle_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> !ctrl.step)
        else $error("request load during a microstep");

endmodule

// ----- src/clcd_seq.sv -----
// ----------------------------------------------------------------------------
// clcd_seq
// Microcode sequencer: step counter, dispatch, conditional jump, nibble
// split and output register.
// ----------------------------------------------------------------------------
module clcd_seq (
    input  logic                clk,
    input  logic                rst_n,
    clcd_req_if.sink            req,
    clcd_xfer_if.source         xfer,
    input  logic [7:0]          byte_val,
    input  logic                four_bit,
    output clcd_pkg::dp_ctrl_t  ctrl
);

    logic                       busy_reg, busy_next;
    logic [clcd_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic                       half_reg, half_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_rs_reg, out_rs_next;
    logic [7:0]                 out_val_reg, out_val_next;
    logic [2:0]                 out_pause_reg, out_pause_next;
    logic                       out_last_reg, out_last_next;

    clcd_pkg::ucode_t           word;
    clcd_pkg::entry_t           entry;
    logic                       accept;
    logic                       can_go;
    logic                       retire;

    assign word   = clcd_pkg::ucode_rom(pc_reg);
    assign entry  = clcd_pkg::entry_pc(req.req_type);
    assign accept = req.valid && req.ready;
    assign can_go = busy_reg && (!out_valid_reg || xfer.ready);

    assign req.ready            = !busy_reg;
    assign xfer.valid           = out_valid_reg;
    assign xfer.register_select = out_rs_reg;
    assign xfer.bus_value       = out_val_reg;
    assign xfer.pause_after_ms  = out_pause_reg;
    assign xfer.last            = out_last_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        out_rs_next    = out_rs_reg;
        out_val_next   = out_val_reg;
        out_pause_next = out_pause_reg;
        out_last_next  = out_last_reg;
        retire         = 1'b0;

        if (out_valid_reg && xfer.ready)
            out_valid_next = 1'b0;

        if (can_go)
        begin
            if (!word.emit)
                retire = 1'b1;
            else if (four_bit && !half_reg)
            begin
                out_valid_next = 1'b1;
                out_rs_next    = word.rs;
                out_val_next   = {4'h0, byte_val[7:4]};
                out_pause_next = 3'd0;
                out_last_next  = 1'b0;
                half_next      = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_rs_next    = word.rs;
                out_val_next   = four_bit ? {4'h0, byte_val[3:0]} : byte_val;
                out_pause_next = word.pause ? clcd_pkg::PAUSE_MS : 3'd0;
                out_last_next  = word.done;
                half_next      = 1'b0;
                retire         = 1'b1;
            end
        end

        if (retire)
        begin
            if (word.done)
                busy_next = 1'b0;
            else if (word.jmp_eight && !four_bit)
                pc_next = word.target;
            else
                pc_next = pc_reg + clcd_pkg::PC_W'(1);
        end

        if (accept && entry.ok)
        begin
            busy_next = 1'b1;
            pc_next   = entry.pc;
            half_next = 1'b0;
        end
    end

    always_comb
    begin
        ctrl.load  = accept;
        ctrl.step  = retire;
        ctrl.src   = word.src;
        ctrl.value = word.value;
        ctrl.sh_op = word.sh_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rs_reg    <= out_rs_next;
        out_val_reg   <= out_val_next;
        out_pause_reg <= out_pause_next;
        out_last_reg  <= out_last_next;
    end

    a_half_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (busy_reg && four_bit))
        else $error("nibble phase set outside a 4-bit request");

    a_known_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && entry.ok) |=> busy_reg)
        else $error("accepted request did not start");

    a_nibble_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !half_reg)
        else $error("last flagged on a high nibble");

endmodule

// ----- src/char_lcd_command_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer_core
// Character-LCD command sequencer: requests in, bus transfers out.
// Flow: a taken request loads the step counter and busy flag, then the first
// transfer is registered; init and display-control requests take one non-emitting step first.
// Throughput: one transfer per cycle while the transfer sink is ready; 8-bit init
// jumps past the wake-up commands, and the 4-bit bus sends each byte as two nibbles.
// Reset: 4-bit bus, 16 columns, 2 rows, display-control shadow 0x0C, idle.
// ----------------------------------------------------------------------------
module char_lcd_command_sequencer_core #(
    parameter int MAX_ROWS = clcd_pkg::MAX_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    clcd_req_if.sink    req,
    clcd_xfer_if.source xfer
);

    clcd_pkg::dp_ctrl_t ctrl;
    logic [7:0]         byte_val;
    logic               four_bit;

    clcd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .xfer     (xfer),
        .byte_val (byte_val),
        .four_bit (four_bit),
        .ctrl     (ctrl)
    );

    clcd_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .ctrl      (ctrl),
        .byte_val  (byte_val),
        .four_bit  (four_bit)
    );

endmodule
